// ----- sv/wbpa_pkg.sv -----
// ----------------------------------------------------------------------------
// wbpa_pkg: white balance pixel apply shared definitions
// Field widths, fixed-point formats, register indexes and the config type.
// ----------------------------------------------------------------------------
package wbpa_pkg;

    localparam int SAMPLE_W  = 16;  // pixel sample field width
    localparam int GAIN_W    = 16;  // Q4.12 gain and saturation width
    localparam int GAIN_FRAC = 12;  // fractional bits of Q4.12
    localparam int PROD_W    = SAMPLE_W + GAIN_W - GAIN_FRAC;  // scaled sample
    localparam int CLIP_W    = SAMPLE_W + 1;                   // holds full scale
    localparam int CURVE_W   = 32;  // Q16.16 tone curve entry
    localparam int TPOS_W    = 29;  // positive blend term, Q.12
    localparam int MUL_W     = TPOS_W + CURVE_W;
    localparam int QSHIFT    = 28;  // Q.12 times Q16.16 back to integer
    localparam int CFG_AW    = 3;

    localparam logic [CLIP_W-1:0]   FULL_WIDE   = 17'h10000;
    localparam logic [CLIP_W-1:0]   FULL_NARROW = 17'h00100;
    localparam logic [SAMPLE_W-1:0] NARROW_MASK = 16'h00FF;

    // Register indexes on the config port
    localparam logic [CFG_AW-1:0] REG_GAIN_RED   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_GAIN_GREEN = 3'd1;
    localparam logic [CFG_AW-1:0] REG_GAIN_BLUE  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_SATURATION = 3'd3;
    localparam logic [CFG_AW-1:0] REG_MODE       = 3'd4;

    // Operation codes of an input word
    localparam logic OP_PIXEL       = 1'b0;
    localparam logic OP_CURVE_WRITE = 1'b1;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd4096;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_red;
        logic [GAIN_W-1:0] gain_green;
        logic [GAIN_W-1:0] gain_blue;
        logic [GAIN_W-1:0] saturation_factor;
        logic              sixteen_bit_mode;
    } cfg_t;

endpackage

// ----- sv/wbpa_ram.sv -----
// ----------------------------------------------------------------------------
// wbpa_ram: generic single-port synchronous RAM
// One access per cycle, write or read; read data registered, held otherwise.
// ----------------------------------------------------------------------------
module wbpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/wbpa_scale.sv -----
// ----------------------------------------------------------------------------
// wbpa_scale: channel gain
// Mask a sample to the active width and scale it by a Q4.12 gain.
// ----------------------------------------------------------------------------
module wbpa_scale
    import wbpa_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [GAIN_W-1:0]   gain,
    input  logic                sixteen_bit_mode,
    output logic [PROD_W-1:0]   product
);

    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
        SAMPLE_W'((32'd1 << SAMPLE_BITS) - 32'd1);

    logic [SAMPLE_W-1:0]        masked;
    logic [SAMPLE_W+GAIN_W-1:0] full;

    always_comb
    begin
        masked = sample & SAMPLE_MASK;
        if (!sixteen_bit_mode)
        begin
            masked = masked & NARROW_MASK;
        end
        full    = masked * gain;
        product = full[SAMPLE_W+GAIN_W-1:GAIN_FRAC];
    end

endmodule

// ----- sv/wbpa_blend.sv -----
// ----------------------------------------------------------------------------
// wbpa_blend: saturation blend
// Form v - sat*(v - r) in Q.12; drop non-positive results to zero.
// ----------------------------------------------------------------------------
module wbpa_blend
    import wbpa_pkg::*;
(
    input  logic [SAMPLE_W-1:0] v,
    input  logic [CLIP_W-1:0]   r,
    input  logic [GAIN_W-1:0]   saturation,
    output logic [TPOS_W-1:0]   tpos
);

    logic signed [CLIP_W:0]          diff;
    logic signed [GAIN_W+CLIP_W+1:0] weighted;
    logic signed [GAIN_W+CLIP_W+2:0] t;

    always_comb
    begin
        diff     = $signed({2'b00, v}) - $signed({1'b0, r});
        weighted = $signed({1'b0, saturation}) * diff;
        t        = $signed({8'd0, v, 12'd0}) - $signed({weighted[GAIN_W+CLIP_W+1], weighted});
        if (!t[GAIN_W+CLIP_W+2] && (t != '0))
        begin
            tpos = t[TPOS_W-1:0];
        end
        else
        begin
            tpos = '0;
        end
    end

endmodule

// ----- sv/white_balance_pixel_apply_top.sv -----
// ----------------------------------------------------------------------------
// white_balance_pixel_apply_top: white balance with tone curve lookup
// Per-channel gain, curve lookup at the brightest channel, saturation blend.
// ----------------------------------------------------------------------------
// Path: a pixel accepted at the input passes the stage 1 to 4 registers and
//   the output register before it shows on out_valid.
// Throughput: one word per cycle if not stalled; RAM: one access per cycle.
// A curve write uses an input slot and yields no output word.
// Reset clears all valid flags and returns the config registers to their
//   defaults; tone curve contents are undefined until written.
module white_balance_pixel_apply_top
    import wbpa_pkg::*;
#(
    parameter int CURVE_DEPTH = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    // config write port
    input  logic                cfg_we,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [GAIN_W-1:0]   cfg_wdata,
    // input channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                operation,
    input  logic [SAMPLE_W-1:0] red_in,
    input  logic [SAMPLE_W-1:0] green_in,
    input  logic [SAMPLE_W-1:0] blue_in,
    input  logic                last_pixel,
    input  logic [SAMPLE_W-1:0] curve_index,
    input  logic [CURVE_W-1:0]  curve_value,
    // output channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic [SAMPLE_W-1:0] red_out,
    output logic [SAMPLE_W-1:0] green_out,
    output logic [SAMPLE_W-1:0] blue_out,
    output logic                frame_end
);

    localparam int CURVE_AW = $clog2(CURVE_DEPTH);
    localparam logic [CLIP_W-1:0] DEPTH_LIM = CLIP_W'(CURVE_DEPTH);

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_GAIN_RED:   cfg_next.gain_red          = cfg_wdata;
                REG_GAIN_GREEN: cfg_next.gain_green        = cfg_wdata;
                REG_GAIN_BLUE:  cfg_next.gain_blue         = cfg_wdata;
                REG_SATURATION: cfg_next.saturation_factor = cfg_wdata;
                REG_MODE:       cfg_next.sixteen_bit_mode  = cfg_wdata[0];
                default:        cfg_next = cfg_reg;  // unmapped index: ignore
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_red          <= GAIN_ONE;
            cfg_reg.gain_green        <= GAIN_ONE;
            cfg_reg.gain_blue         <= GAIN_ONE;
            cfg_reg.saturation_factor <= GAIN_ONE;
            cfg_reg.sixteen_bit_mode  <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Full scale and its clip limit follow the sample mode
    logic [CLIP_W-1:0]   full_scale;
    logic [SAMPLE_W-1:0] full_m1;

    assign full_scale = cfg_reg.sixteen_bit_mode ? FULL_WIDE : FULL_NARROW;
    assign full_m1    = SAMPLE_W'(full_scale - CLIP_W'(1));

    // ------------------------------------------------------------------
    // Pipeline flow control: each stage takes a word when it is empty or
    // its word moves on. Only a full pipe behind a stalled output blocks.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic s1_valid_next, s2_valid_next, s3_valid_next, s4_valid_next, out_valid_next;
    logic s1_op_reg;
    logic ready_out, ready4, ready3, ready2, ready1;

    assign ready_out = !out_valid_reg || !out_stall;
    assign ready4    = !s4_valid_reg || ready_out;
    assign ready3    = !s3_valid_reg || ready4;
    assign ready2    = !s2_valid_reg || ready3;
    // A curve write leaves stage 1 straight into the RAM, so it never waits
    assign ready1    = !s1_valid_reg || (s1_op_reg == OP_CURVE_WRITE) || ready2;

    assign in_stall  = !ready1;

    always_comb
    begin
        s1_valid_next  = ready1    ? in_valid : s1_valid_reg;
        s2_valid_next  = ready2    ? (s1_valid_reg && (s1_op_reg == OP_PIXEL)) : s2_valid_reg;
        s3_valid_next  = ready3    ? s2_valid_reg : s3_valid_reg;
        s4_valid_next  = ready4    ? s3_valid_reg : s4_valid_reg;
        out_valid_next = ready_out ? s4_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            s4_valid_reg  <= s4_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: channel gains
    // ------------------------------------------------------------------
    logic [PROD_W-1:0]   pr_next, pg_next, pb_next;
    logic [PROD_W-1:0]   s1_pr_reg, s1_pg_reg, s1_pb_reg;
    logic                s1_last_reg;
    logic [SAMPLE_W-1:0] s1_idx_reg;
    logic [CURVE_W-1:0]  s1_val_reg;

    wbpa_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale_red (
        .sample           (red_in),
        .gain             (cfg_reg.gain_red),
        .sixteen_bit_mode (cfg_reg.sixteen_bit_mode),
        .product          (pr_next)
    );

    wbpa_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale_green (
        .sample           (green_in),
        .gain             (cfg_reg.gain_green),
        .sixteen_bit_mode (cfg_reg.sixteen_bit_mode),
        .product          (pg_next)
    );

    wbpa_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale_blue (
        .sample           (blue_in),
        .gain             (cfg_reg.gain_blue),
        .sixteen_bit_mode (cfg_reg.sixteen_bit_mode),
        .product          (pb_next)
    );

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            s1_op_reg   <= operation;
            s1_last_reg <= last_pixel;
            s1_pr_reg   <= pr_next;
            s1_pg_reg   <= pg_next;
            s1_pb_reg   <= pb_next;
            s1_idx_reg  <= curve_index;
            s1_val_reg  <= curve_value;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 -> 2: curve index, clipping and the RAM access.
    // Writes and reads reach the RAM in input order through this one port,
    // so a pixel always sees every curve write accepted before it.
    // ------------------------------------------------------------------
    logic [PROD_W-1:0]   pmax;
    logic [SAMPLE_W-1:0] v_next;
    logic [CLIP_W-1:0]   rr_next, rg_next, rb_next;
    logic                hit_next;
    logic                idx_ok;
    logic                ram_en, ram_we;
    logic [CURVE_AW-1:0] ram_addr;
    logic [CURVE_W-1:0]  ram_rdata;

    function automatic logic [CLIP_W-1:0] clip_full(input logic [PROD_W-1:0] p,
                                                    input logic [CLIP_W-1:0] fs);
        if (p > PROD_W'(fs))
        begin
            return fs;
        end
        return p[CLIP_W-1:0];
    endfunction

    always_comb
    begin
        pmax = s1_pr_reg;
        if (s1_pg_reg > pmax)
        begin
            pmax = s1_pg_reg;
        end
        if (s1_pb_reg > pmax)
        begin
            pmax = s1_pb_reg;
        end
        v_next   = (pmax > PROD_W'(full_m1)) ? full_m1 : pmax[SAMPLE_W-1:0];
        rr_next  = clip_full(s1_pr_reg, full_scale);
        rg_next  = clip_full(s1_pg_reg, full_scale);
        rb_next  = clip_full(s1_pb_reg, full_scale);
        hit_next = {1'b0, v_next} < DEPTH_LIM;
        idx_ok   = {1'b0, s1_idx_reg} < DEPTH_LIM;

        ram_we   = s1_valid_reg && (s1_op_reg == OP_CURVE_WRITE) && idx_ok;
        ram_en   = ram_we ||
                   (s1_valid_reg && (s1_op_reg == OP_PIXEL) && ready2 && hit_next);
        ram_addr = (s1_op_reg == OP_CURVE_WRITE) ? s1_idx_reg[CURVE_AW-1:0]
                                                 : v_next[CURVE_AW-1:0];
    end

    wbpa_ram #(
        .WIDTH (CURVE_W),
        .DEPTH (CURVE_DEPTH)
    ) u_curve_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s1_val_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 2: curve entry arrives; form the blend terms.
    // The RAM output holds while stage 2 holds, since no read is issued.
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] s2_v_reg;
    logic [CLIP_W-1:0]   s2_rr_reg, s2_rg_reg, s2_rb_reg;
    logic                s2_hit_reg, s2_last_reg;
    logic [CURVE_W-1:0]  curve_next;
    logic [TPOS_W-1:0]   tr_next, tg_next, tb_next;

    always_ff @(posedge clk)
    begin
        if (ready2)
        begin
            s2_v_reg    <= v_next;
            s2_rr_reg   <= rr_next;
            s2_rg_reg   <= rg_next;
            s2_rb_reg   <= rb_next;
            s2_hit_reg  <= hit_next;
            s2_last_reg <= s1_last_reg;
        end
    end

    // Index beyond the table reads as a zero gain
    assign curve_next = s2_hit_reg ? ram_rdata : '0;

    wbpa_blend u_blend_red (
        .v          (s2_v_reg),
        .r          (s2_rr_reg),
        .saturation (cfg_reg.saturation_factor),
        .tpos       (tr_next)
    );

    wbpa_blend u_blend_green (
        .v          (s2_v_reg),
        .r          (s2_rg_reg),
        .saturation (cfg_reg.saturation_factor),
        .tpos       (tg_next)
    );

    wbpa_blend u_blend_blue (
        .v          (s2_v_reg),
        .r          (s2_rb_reg),
        .saturation (cfg_reg.saturation_factor),
        .tpos       (tb_next)
    );

    // ------------------------------------------------------------------
    // Stage 3: blend terms and curve gain registered
    // ------------------------------------------------------------------
    logic [TPOS_W-1:0]  s3_tr_reg, s3_tg_reg, s3_tb_reg;
    logic [CURVE_W-1:0] s3_curve_reg;
    logic               s3_last_reg;

    always_ff @(posedge clk)
    begin
        if (ready3)
        begin
            s3_tr_reg    <= tr_next;
            s3_tg_reg    <= tg_next;
            s3_tb_reg    <= tb_next;
            s3_curve_reg <= curve_next;
            s3_last_reg  <= s2_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: apply the curve gain
    // ------------------------------------------------------------------
    logic [MUL_W-1:0] mr_next, mg_next, mb_next;
    logic [MUL_W-1:0] s4_mr_reg, s4_mg_reg, s4_mb_reg;
    logic             s4_last_reg;

    assign mr_next = s3_tr_reg * s3_curve_reg;
    assign mg_next = s3_tg_reg * s3_curve_reg;
    assign mb_next = s3_tb_reg * s3_curve_reg;

    always_ff @(posedge clk)
    begin
        if (ready4)
        begin
            s4_mr_reg   <= mr_next;
            s4_mg_reg   <= mg_next;
            s4_mb_reg   <= mb_next;
            s4_last_reg <= s3_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: drop the fraction, saturate at full scale minus one
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] red_out_reg, green_out_reg, blue_out_reg;
    logic                frame_end_reg;

    function automatic logic [SAMPLE_W-1:0] sat_out(input logic [MUL_W-1:0] m,
                                                    input logic [SAMPLE_W-1:0] lim);
        logic [MUL_W-QSHIFT-1:0] q;
        q = m[MUL_W-1:QSHIFT];
        if (q > (MUL_W-QSHIFT)'(lim))
        begin
            return lim;
        end
        return q[SAMPLE_W-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (ready_out)
        begin
            red_out_reg   <= sat_out(s4_mr_reg, full_m1);
            green_out_reg <= sat_out(s4_mg_reg, full_m1);
            blue_out_reg  <= sat_out(s4_mb_reg, full_m1);
            frame_end_reg <= s4_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = red_out_reg;
    assign green_out = green_out_reg;
    assign blue_out  = blue_out_reg;
    assign frame_end = frame_end_reg;

endmodule

// ----- sv/wbpa_checker.sv -----
// ----------------------------------------------------------------------------
// wbpa_checker: port-level checks for white balance pixel apply
// Output handshake, reset state and input back-pressure.
// ----------------------------------------------------------------------------
module wbpa_checker
    import wbpa_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic [SAMPLE_W-1:0] red_out,
    input logic [SAMPLE_W-1:0] green_out,
    input logic [SAMPLE_W-1:0] blue_out,
    input logic                frame_end
);

    // A stalled output word keeps its valid
    a_out_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    // A stalled output word keeps its payload
    a_out_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(red_out) && $stable(green_out) &&
                                   $stable(blue_out) && $stable(frame_end))
        else $error("output payload changed while stalled");

    // Reset leaves no output word behind
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("out_valid high after a reset cycle");

    // Input back-pressure only comes from a blocked output word
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output is free (in_valid=%0b)", in_valid);

endmodule

bind white_balance_pixel_apply_top wbpa_checker u_wbpa_checker (.*);
